@@ src/gtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// gtpc_pkg
// Shared types and constants for the grid tile path connectivity block.
// ----------------------------------------------------------------------------
package gtpc_pkg;

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int REG_W      = 7;
  localparam int REG_IDX_LSB = 2;
  localparam int TILE_W     = 3;
  localparam int RANK_W     = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam logic [3:0] SIDE_L = 4'b0001;
  localparam logic [3:0] SIDE_R = 4'b0010;
  localparam logic [3:0] SIDE_U = 4'b0100;
  localparam logic [3:0] SIDE_D = 4'b1000;

  localparam logic [TILE_W-1:0] TILE_LR = 3'd1;
  localparam logic [TILE_W-1:0] TILE_UD = 3'd2;
  localparam logic [TILE_W-1:0] TILE_LD = 3'd3;
  localparam logic [TILE_W-1:0] TILE_RD = 3'd4;
  localparam logic [TILE_W-1:0] TILE_LU = 3'd5;
  localparam logic [TILE_W-1:0] TILE_RU = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_FIND_GO,
    OP_FIND_WALK,
    OP_COMP_WALK,
    OP_FIND_END,
    OP_RANK_A,
    OP_RANK_B,
    OP_LINK,
    OP_STEP,
    OP_RESULT
  } op_t;

  typedef enum logic [2:0] {
    JOB_LEFT_NB,
    JOB_LEFT_ME,
    JOB_UP_NB,
    JOB_UP_ME,
    JOB_END_FIRST,
    JOB_END_LAST
  } job_t;

  typedef struct packed {
    op_t  op;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic pd_is_cur;
    logic start_is_cur;
    logic pd_is_root;
    logic join_left;
    logic join_up;
    logic roots_equal;
    logic last_cell;
    logic out_free;
  } sts_t;

  // Open sides of each street tile; unknown codes have none.
  function automatic logic [3:0] tile_sides(input logic [TILE_W-1:0] t);
    logic [3:0] s;
    case (t)
      TILE_LR: s = SIDE_L | SIDE_R;
      TILE_UD: s = SIDE_U | SIDE_D;
      TILE_LD: s = SIDE_L | SIDE_D;
      TILE_RD: s = SIDE_R | SIDE_D;
      TILE_LU: s = SIDE_L | SIDE_U;
      TILE_RU: s = SIDE_R | SIDE_U;
      default: s = 4'b0000;
    endcase
    return s;
  endfunction

endpackage

@@ src/gtpc_regs.sv @@
// ----------------------------------------------------------------------------
// gtpc_regs
// Configuration registers for grid size, with range clamping and restart.
// ----------------------------------------------------------------------------
module gtpc_regs #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gtpc_pkg::APB_AW-1:0]           paddr,
  input  logic [gtpc_pkg::APB_DW-1:0]           pwdata,
  output logic [gtpc_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready,
  output logic [$clog2(MAX_ROWS+1)-1:0]         rows_eff,
  output logic [$clog2(MAX_COLS+1)-1:0]         cols_eff,
  output logic                                  restart
);
  import gtpc_pkg::*;

  localparam int RDW = $clog2(MAX_ROWS + 1);
  localparam int CDW = $clog2(MAX_COLS + 1);

  logic [REG_W-1:0] rows_r;
  logic [REG_W-1:0] cols_r;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_LSB];
  assign wr_en   = psel & penable & pwrite & pready;
  assign restart = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= REG_W'(1);
      cols_r <= REG_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GRID_ROWS: rows_r <= pwdata[REG_W-1:0];
        REG_GRID_COLS: cols_r <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_ROWS: prdata = {{(APB_DW-REG_W){1'b0}}, rows_r};
      REG_GRID_COLS: prdata = {{(APB_DW-REG_W){1'b0}}, cols_r};
    endcase
  end

  always_comb begin
    if (rows_r == '0) begin
      rows_eff = RDW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(rows_r);
    end
    if (cols_r == '0) begin
      cols_eff = CDW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(cols_r);
    end
  end

endmodule

@@ src/gtpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gtpc_ctrl
// Sequencer that walks each cell through its joins and the final root check.
// ----------------------------------------------------------------------------
module gtpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output gtpc_pkg::cmd_t cmd,
  input  gtpc_pkg::sts_t sts
);
  import gtpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUTE,
    ST_FIND_GO,
    ST_FIND_WALK,
    ST_COMP_WALK,
    ST_FIND_END,
    ST_RANK_A,
    ST_RANK_B,
    ST_LINK,
    ST_STEP,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic   go_up;

  assign in_stall = (state_r != ST_IDLE);
  assign go_up    = (job_r == JOB_LEFT_ME) && sts.join_up;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cmd.job   = job_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = ST_ROUTE;
      end
      ST_ROUTE: begin
        if (sts.join_left) begin
          state_nxt = ST_FIND_GO;
          job_nxt   = JOB_LEFT_NB;
        end else if (sts.join_up) begin
          state_nxt = ST_FIND_GO;
          job_nxt   = JOB_UP_NB;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_FIND_GO: begin
        cmd.op    = OP_FIND_GO;
        state_nxt = ST_FIND_WALK;
      end
      ST_FIND_WALK: begin
        cmd.op = OP_FIND_WALK;
        if (sts.pd_is_cur) begin
          state_nxt = sts.start_is_cur ? ST_FIND_END : ST_COMP_WALK;
        end
      end
      ST_COMP_WALK: begin
        cmd.op = OP_COMP_WALK;
        if (sts.pd_is_root) begin
          state_nxt = ST_FIND_END;
        end
      end
      ST_FIND_END: begin
        cmd.op = OP_FIND_END;
        case (job_r)
          JOB_LEFT_NB: begin
            state_nxt = ST_FIND_GO;
            job_nxt   = JOB_LEFT_ME;
          end
          JOB_UP_NB: begin
            state_nxt = ST_FIND_GO;
            job_nxt   = JOB_UP_ME;
          end
          JOB_END_FIRST: begin
            state_nxt = ST_FIND_GO;
            job_nxt   = JOB_END_LAST;
          end
          JOB_END_LAST: state_nxt = ST_RESULT;
          default:      state_nxt = ST_RANK_A;
        endcase
      end
      ST_RANK_A: begin
        cmd.op = OP_RANK_A;
        if (sts.roots_equal) begin
          if (go_up) begin
            state_nxt = ST_FIND_GO;
            job_nxt   = JOB_UP_NB;
          end else begin
            state_nxt = ST_STEP;
          end
        end else begin
          state_nxt = ST_RANK_B;
        end
      end
      ST_RANK_B: begin
        cmd.op    = OP_RANK_B;
        state_nxt = ST_LINK;
      end
      ST_LINK: begin
        cmd.op = OP_LINK;
        if (go_up) begin
          state_nxt = ST_FIND_GO;
          job_nxt   = JOB_UP_NB;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.op = OP_STEP;
        if (sts.last_cell) begin
          state_nxt = ST_FIND_GO;
          job_nxt   = JOB_END_FIRST;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESULT: begin
        cmd.op = OP_RESULT;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= JOB_LEFT_NB;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

endmodule

@@ src/gtpc_dp.sv @@
// ----------------------------------------------------------------------------
// gtpc_dp
// Datapath with the parent, rank and previous-row memories, position
// counters, root registers and the result register.
// ----------------------------------------------------------------------------
module gtpc_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gtpc_pkg::cmd_t                     cmd,
  output gtpc_pkg::sts_t                     sts,
  input  logic [gtpc_pkg::TILE_W-1:0]        in_tile,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      rows_eff,
  input  logic [$clog2(MAX_COLS+1)-1:0]      cols_eff,
  input  logic                               restart,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_has_path
);
  import gtpc_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int CDW   = $clog2(MAX_COLS + 1);

  logic [IW-1:0]     parent_mem [CELLS];
  logic [RANK_W-1:0] rank_mem [CELLS];
  logic [TILE_W-1:0] prev_mem [MAX_COLS];

  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_r;
  logic [IW-1:0]     me_r;
  logic [TILE_W-1:0] left_tile_r;
  logic              out_valid_r;
  logic              out_has_path_r;

  logic [TILE_W-1:0] tile_r;
  logic [TILE_W-1:0] prev_rd;
  logic              join_left_r;
  logic              join_up_r;
  logic [IW-1:0]     start_r;
  logic [IW-1:0]     cur_r;
  logic [IW-1:0]     root_r;
  logic [IW-1:0]     a_r;
  logic [IW-1:0]     b_r;
  logic [IW-1:0]     end_idx_r;
  logic [RANK_W-1:0] rank_a_r;
  logic [IW-1:0]     par_rd;
  logic [RANK_W-1:0] rank_rd;

  logic [IW-1:0]     par_raddr;
  logic [IW-1:0]     par_waddr;
  logic [IW-1:0]     par_wdata;
  logic              par_we;
  logic [IW-1:0]     rank_raddr;
  logic [IW-1:0]     rank_waddr;
  logic [RANK_W-1:0] rank_wdata;
  logic              rank_we;
  logic [IW-1:0]     start_addr;
  logic [IW-1:0]     up_addr;
  logic              last_col;
  logic              last_row;
  logic              out_free;
  logic [3:0]        me_sides;

  assign up_addr  = IW'({1'b0, me_r} - (IW+1)'(cols_eff));
  assign last_col = (CDW'(col_r) + CDW'(1)) == cols_eff;
  assign last_row = (RDW'(row_r) + RDW'(1)) == rows_eff;
  assign out_free = !out_valid_r || !out_stall;
  assign me_sides = tile_sides(tile_r);

  assign sts.pd_is_cur    = (par_rd == cur_r);
  assign sts.start_is_cur = (start_r == cur_r);
  assign sts.pd_is_root   = (par_rd == root_r);
  assign sts.join_left    = join_left_r;
  assign sts.join_up      = join_up_r;
  assign sts.roots_equal  = (a_r == b_r);
  assign sts.last_cell    = last_col && last_row;
  assign sts.out_free     = out_free;

  assign out_valid    = out_valid_r;
  assign out_has_path = out_has_path_r;

  always_comb begin
    case (cmd.job)
      JOB_LEFT_NB:   start_addr = me_r - IW'(1);
      JOB_UP_NB:     start_addr = up_addr;
      JOB_END_FIRST: start_addr = '0;
      JOB_END_LAST:  start_addr = end_idx_r;
      default:       start_addr = me_r;
    endcase
  end

  always_comb begin
    par_raddr  = cur_r;
    par_waddr  = me_r;
    par_wdata  = me_r;
    par_we     = 1'b0;
    rank_raddr = a_r;
    rank_waddr = me_r;
    rank_wdata = '0;
    rank_we    = 1'b0;
    case (cmd.op)
      OP_ACCEPT: begin
        par_we  = 1'b1;
        rank_we = 1'b1;
      end
      OP_FIND_GO: par_raddr = start_addr;
      OP_FIND_WALK: par_raddr = sts.pd_is_cur ? start_r : par_rd;
      OP_COMP_WALK: begin
        par_raddr = par_rd;
        par_we    = 1'b1;
        par_waddr = cur_r;
        par_wdata = root_r;
      end
      OP_RANK_B: rank_raddr = b_r;
      OP_LINK: begin
        par_we = 1'b1;
        if (rank_a_r < rank_rd) begin
          par_waddr = a_r;
          par_wdata = b_r;
        end else begin
          par_waddr = b_r;
          par_wdata = a_r;
          if (rank_a_r == rank_rd && rank_a_r != RANK_MAX) begin
            rank_we    = 1'b1;
            rank_waddr = a_r;
            rank_wdata = rank_a_r + RANK_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_rd <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rd <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT) begin
      prev_mem[col_r] <= tile_r;
    end
    prev_rd <= prev_mem[col_r];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: tile_r <= in_tile;
      OP_INIT: begin
        join_left_r <= (col_r != '0) && ((me_sides & SIDE_L) != '0) &&
                       ((tile_sides(left_tile_r) & SIDE_R) != '0);
        join_up_r   <= (row_r != '0) && ((me_sides & SIDE_U) != '0) &&
                       ((tile_sides(prev_rd) & SIDE_D) != '0);
      end
      OP_FIND_GO: begin
        start_r <= start_addr;
        cur_r   <= start_addr;
      end
      OP_FIND_WALK: begin
        if (sts.pd_is_cur) begin
          root_r <= cur_r;
          cur_r  <= start_r;
        end else begin
          cur_r <= par_rd;
        end
      end
      OP_COMP_WALK: cur_r <= par_rd;
      OP_FIND_END: begin
        case (cmd.job) inside
          JOB_LEFT_NB, JOB_UP_NB, JOB_END_FIRST: a_r <= root_r;
          default:                               b_r <= root_r;
        endcase
      end
      OP_RANK_B: rank_a_r <= rank_rd;
      OP_STEP: end_idx_r <= me_r;
      OP_RESULT: begin
        if (out_free) begin
          out_has_path_r <= sts.roots_equal;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      me_r        <= '0;
      left_tile_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        row_r       <= '0;
        col_r       <= '0;
        me_r        <= '0;
        left_tile_r <= '0;
      end else if (cmd.op == OP_STEP) begin
        if (last_col) begin
          col_r       <= '0;
          left_tile_r <= '0;
          if (last_row) begin
            row_r <= '0;
            me_r  <= '0;
          end else begin
            row_r <= row_r + RW'(1);
            me_r  <= me_r + IW'(1);
          end
        end else begin
          col_r       <= col_r + CW'(1);
          me_r        <= me_r + IW'(1);
          left_tile_r <= tile_r;
        end
      end
      if (cmd.op == OP_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ src/grid_tile_path_connectivity.sv @@
// ----------------------------------------------------------------------------
// grid_tile_path_connectivity
// Checks whether a street-tile grid links its top-left and bottom-right cells.
// ----------------------------------------------------------------------------
// Tiles enter in raster order on the in_ channel, one word per cell, and
// each cell is joined to its left and upper neighbors by union-find with
// union by rank and path compression. After the last cell of the grid one
// word on the out_ channel reports whether the two corner cells connect.
// The grid size is set through the APB port and any write restarts the grid.
// A cell that joins nothing passes through accept, init, route and step. A join
// adds two root searches and a rank step, plus a second rank step and a link
// if the roots differ. Root searches walk the parent memory one read per cycle,
// and path compression revisits the same links. The last cell adds two more
// root searches and a result load step. Items are taken one at a time.
// Reset returns the position to the top-left cell, sets both sizes to 1 and
// empties the output register. The output register lets the next grid start
// while a result waits; a stalled receiver holds the block only when a
// second result is ready before the first has been taken.
module grid_tile_path_connectivity #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gtpc_pkg::TILE_W-1:0]          in_tile,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_has_path,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gtpc_pkg::APB_AW-1:0]          paddr,
  input  logic [gtpc_pkg::APB_DW-1:0]          pwdata,
  output logic [gtpc_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import gtpc_pkg::*;

  logic [$clog2(MAX_ROWS+1)-1:0] rows_eff;
  logic [$clog2(MAX_COLS+1)-1:0] cols_eff;
  logic                          restart;
  cmd_t                          cmd;
  sts_t                          sts;

  gtpc_regs #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .restart  (restart)
  );

  gtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  gtpc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_tile      (in_tile),
    .rows_eff     (rows_eff),
    .cols_eff     (cols_eff),
    .restart      (restart),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_has_path (out_has_path)
  );

endmodule
